// ===== src/wsd_pkg.sv =====
// wsd_pkg: shared types and constants for the websocket frame deframer
// no dependencies; used by wsd_parser and websocket_frame_deframer
`default_nettype none

package wsd_pkg;

  // request and result payloads
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       from_active_link;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text_byte;
    logic       last;
  } out_t;

  // link commands
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  // result kinds
  localparam logic [2:0] K_TEXT_BYTE  = 3'd0;
  localparam logic [2:0] K_EMPTY_TEXT = 3'd1;
  localparam logic [2:0] K_PONG       = 3'd2;
  localparam logic [2:0] K_CLOSE      = 3'd3;
  localparam logic [2:0] K_BAD_LEN    = 3'd4;
  localparam logic [2:0] K_OVERSIZE   = 3'd5;

  // frame opcodes
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // 7-bit length codes
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

endpackage

`default_nettype wire

// ===== src/websocket_frame_deframer.sv =====
// websocket_frame_deframer: one received byte per request in, zero or one event out
// latency: a result is valid the cycle after its request is accepted (one register)
// throughput: one request per cycle; the output register stalls intake only while full
//   and not being taken
// reset (rst_n, synchronous): link down, parser cleared, payload limit back to 1024
// depends on wsd_pkg and wsd_parser
`default_nettype none

module websocket_frame_deframer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire wsd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wsd_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata
);

  logic [15:0]   max_len_r;
  logic          out_valid_r;
  wsd_pkg::out_t out_data_r;
  logic          accept;
  logic          res_valid;
  wsd_pkg::out_t res;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // payload limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .req         (in_data),
    .max_payload (max_len_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== src/wsd_parser.sv =====
// wsd_parser: frame header state machine, mask key capture and payload unmasking
// depends on wsd_pkg
`default_nettype none

module wsd_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire wsd_pkg::in_t  req,
  input  wire logic [15:0]   max_payload,
  output logic               res_valid,
  output wsd_pkg::out_t      res
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_KEY  = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;

  logic        link_r,  link_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  op_r,    op_nxt;
  logic        fin_r,   fin_nxt;
  logic        mask_r,  mask_nxt;
  logic [15:0] len_r,   len_nxt;
  logic [15:0] cnt_r,   cnt_nxt;
  logic [31:0] key_r,   key_nxt;
  logic        skip_r,  skip_nxt;

  logic        len_done;
  logic        hdr_done;
  logic        frame_end;
  logic        clear;
  logic        is_last;
  logic [16:0] cnt_inc;
  logic [7:0]  key_byte;

  assign cnt_inc = {1'b0, cnt_r} + 17'd1;
  assign is_last = cnt_inc >= {1'b0, len_r};

  // key byte for the current payload index, first received key byte first
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state and result for one request
  always_comb begin
    link_nxt  = link_r;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    skip_nxt  = skip_r;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    frame_end = 1'b0;
    clear     = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (req.cmd == wsd_pkg::CMD_OPEN) begin
      link_nxt = 1'b1;
      clear    = 1'b1;
    end else if (req.cmd == wsd_pkg::CMD_CLOSE) begin
      link_nxt = 1'b0;
      clear    = 1'b1;
    end else if (req.cmd == wsd_pkg::CMD_BYTE && link_r && req.from_active_link) begin
      unique case (phase_r)
        PH_HDR0: begin
          op_nxt    = req.rx_byte[3:0];
          fin_nxt   = req.rx_byte[7];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          mask_nxt = req.rx_byte[7];
          if (req.rx_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
            link_nxt  = 1'b0;
            clear     = 1'b1;
            res_valid = 1'b1;
            res.kind  = wsd_pkg::K_BAD_LEN;
          end else if (req.rx_byte[6:0] == wsd_pkg::LEN_CODE_16) begin
            phase_nxt = PH_LENH;
          end else begin
            len_nxt  = {9'd0, req.rx_byte[6:0]};
            len_done = 1'b1;
          end
        end
        PH_LENH: begin
          len_nxt   = {req.rx_byte, 8'd0};
          phase_nxt = PH_LENL;
        end
        PH_LENL: begin
          len_nxt  = {len_r[15:8], len_r[7:0] | req.rx_byte};
          len_done = 1'b1;
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], req.rx_byte};
          cnt_nxt = cnt_inc[15:0];
          if (cnt_inc >= 17'd4) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          cnt_nxt = cnt_inc[15:0];
          if (skip_r) begin
            clear = is_last;
          end else if (op_r == wsd_pkg::OP_TEXT && fin_r) begin
            res_valid     = 1'b1;
            res.kind      = wsd_pkg::K_TEXT_BYTE;
            res.text_byte = mask_r ? (req.rx_byte ^ key_byte) : req.rx_byte;
            res.last      = is_last;
            clear         = is_last;
          end else begin
            frame_end = is_last;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase

      // length complete: key next or header finished
      if (len_done) begin
        if (mask_r || mask_nxt) begin
          if (mask_nxt) begin
            phase_nxt = PH_KEY;
            cnt_nxt   = '0;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          hdr_done = 1'b1;
        end
      end

      // header complete
      if (hdr_done) begin
        cnt_nxt = '0;
        if (len_nxt > max_payload) begin
          skip_nxt  = 1'b1;
          phase_nxt = PH_DATA;
          res_valid = 1'b1;
          res.kind  = wsd_pkg::K_OVERSIZE;
        end else if (len_nxt == '0) begin
          if (op_r == wsd_pkg::OP_TEXT && fin_r) begin
            clear     = 1'b1;
            res_valid = 1'b1;
            res.kind  = wsd_pkg::K_EMPTY_TEXT;
          end else begin
            frame_end = 1'b1;
          end
        end else begin
          phase_nxt = PH_DATA;
        end
      end

      // whole frame received
      if (frame_end) begin
        clear = 1'b1;
        if (op_r == wsd_pkg::OP_CLOSE) begin
          link_nxt  = 1'b0;
          res_valid = 1'b1;
          res.kind  = wsd_pkg::K_CLOSE;
        end else if (op_r == wsd_pkg::OP_PING) begin
          res_valid = 1'b1;
          res.kind  = wsd_pkg::K_PONG;
        end
      end
    end

    if (clear) begin
      phase_nxt = PH_HDR0;
      op_nxt    = '0;
      fin_nxt   = 1'b0;
      mask_nxt  = 1'b0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      key_nxt   = '0;
      skip_nxt  = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r  <= 1'b0;
      phase_r <= PH_HDR0;
      op_r    <= '0;
      fin_r   <= 1'b0;
      mask_r  <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
      key_r   <= '0;
      skip_r  <= 1'b0;
    end else if (step) begin
      link_r  <= link_nxt;
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

`default_nettype wire
